>>> sv/fbc_pkg.sv
// Shared widths, types, reset values and verdict codes for the frustum box cull core.
package fbc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int ELEM_HALF  = CFG_DATA_W / 2;

    localparam int CTR_FIELD_W  = 32;
    localparam int HALF_FIELD_W = 31;
    localparam int HALF_LSB     = 3 * CTR_FIELD_W;
    localparam int IN_BITS      = HALF_LSB + 3 * HALF_FIELD_W;
    localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    localparam int VERDICT_W = 2;
    localparam int M_TDATA_W = 8;

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int NRM_W  = COORD_WIDTH + 1;
    localparam int ACC_W  = 2 * COORD_WIDTH + 8;

    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_ROWS   = 4;
    localparam int ROW_W      = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-2:0] half_t;
    typedef logic signed [NRM_W-1:0]       nrm_t;
    typedef logic        [NRM_W-1:0]       nmag_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic        [PROD_W-1:0]      uprod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_INSIDE  = 2'd0,
        VERDICT_PARTIAL = 2'd1,
        VERDICT_OUTSIDE = 2'd2
    } verdict_t;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

endpackage

>>> sv/frustum_box_cull_core.sv
// Frustum versus center/extent box classifier, five register stages deep.
// m_tvalid is v5_reg; each stage advances on its own, so bubbles fill during stalls.
// Throughput: one box per cycle unless m_tready or cfg_valid stalls the input.
// s_tready drops in a cycle with a configuration beat; plane terms follow a write via plane_mag_reg and plane_w_reg.
// Synchronous active-low reset empties the pipeline and loads the identity matrix.
module frustum_box_cull_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
    input  logic [fbc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // verdict, zero pad
    output logic [fbc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fbc_pkg::*;

    logic [CFG_DATA_W-1:0] cfg_reg [NUM_REGS];
    coord_t elem [NUM_ROWS][NUM_ROWS];

    nmag_t plane_mag_reg  [NUM_PLANES][NUM_AXES];
    nmag_t plane_mag_next [NUM_PLANES][NUM_AXES];
    nrm_t  plane_w_reg    [NUM_PLANES];
    nrm_t  plane_w_next   [NUM_PLANES];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic accept;

    coord_t ctr1_reg  [NUM_AXES];
    coord_t ctr1_next [NUM_AXES];
    half_t  half1_reg [NUM_AXES];
    half_t  half1_next[NUM_AXES];

    prod_t  rowprod2_reg  [NUM_ROWS][NUM_AXES];
    prod_t  rowprod2_next [NUM_ROWS][NUM_AXES];
    uprod_t rprod2_reg    [NUM_PLANES][NUM_AXES];
    uprod_t rprod2_next   [NUM_PLANES][NUM_AXES];

    acc_t rowsum3_reg  [NUM_ROWS];
    acc_t rowsum3_next [NUM_ROWS];
    acc_t rsum3_reg    [NUM_PLANES];
    acc_t rsum3_next   [NUM_PLANES];

    acc_t dw4_reg  [NUM_PLANES];
    acc_t dw4_next [NUM_PLANES];
    acc_t r4_reg   [NUM_PLANES];

    verdict_t verdict5_reg, verdict5_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            cfg_reg[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_ROWS; c++) begin
            for (int k = 0; k < NUM_ROWS; k++) begin
                if (k % 2 == 1) begin
                    elem[c][k] = cfg_reg[2*c + k/2][ELEM_HALF +: COORD_WIDTH];
                end else begin
                    elem[c][k] = cfg_reg[2*c + k/2][0 +: COORD_WIDTH];
                end
            end
        end
    end

    // plane normals and offsets, refreshed every cycle
    always_comb begin
        nrm_t n;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                if (p % 2 == 1) begin
                    n = nrm_t'(elem[c][ROW_W]) - nrm_t'(elem[c][p/2]);
                end else begin
                    n = nrm_t'(elem[c][ROW_W]) + nrm_t'(elem[c][p/2]);
                end
                plane_mag_next[p][c] = n[NRM_W-1] ? nmag_t'(-n) : nmag_t'(n);
            end
            if (p % 2 == 1) begin
                plane_w_next[p] = nrm_t'(elem[ROW_W][ROW_W]) - nrm_t'(elem[ROW_W][p/2]);
            end else begin
                plane_w_next[p] = nrm_t'(elem[ROW_W][ROW_W]) + nrm_t'(elem[ROW_W][p/2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        plane_mag_reg <= plane_mag_next;
        plane_w_reg   <= plane_w_next;
    end

    // stage handshake
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && !cfg_valid;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= accept;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: unpack the beat
    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            ctr1_next[c]  = s_tdata[c*CTR_FIELD_W +: COORD_WIDTH];
            half1_next[c] = s_tdata[HALF_LSB + c*HALF_FIELD_W +: COORD_WIDTH-1];
        end
    end

    // stage 2: products
    always_comb begin
        for (int k = 0; k < NUM_ROWS; k++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                rowprod2_next[k][c] = prod_t'(elem[c][k]) * prod_t'(ctr1_reg[c]);
            end
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                rprod2_next[p][c] = uprod_t'(plane_mag_reg[p][c]) * uprod_t'(half1_reg[c]);
            end
        end
    end

    // stage 3: row dot products and extent sums
    always_comb begin
        for (int k = 0; k < NUM_ROWS; k++) begin
            rowsum3_next[k] = acc_t'(rowprod2_reg[k][0]) + acc_t'(rowprod2_reg[k][1])
                            + acc_t'(rowprod2_reg[k][2]);
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            rsum3_next[p] = acc_t'(rprod2_reg[p][0]) + acc_t'(rprod2_reg[p][1])
                          + acc_t'(rprod2_reg[p][2]);
        end
    end

    // stage 4: plane distance plus aligned offset
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (p % 2 == 1) begin
                dw4_next[p] = rowsum3_reg[ROW_W] - rowsum3_reg[p/2]
                            + (acc_t'(plane_w_reg[p]) <<< FRAC_BITS);
            end else begin
                dw4_next[p] = rowsum3_reg[ROW_W] + rowsum3_reg[p/2]
                            + (acc_t'(plane_w_reg[p]) <<< FRAC_BITS);
            end
        end
    end

    // stage 5: sign tests and verdict
    always_comb begin
        acc_t far_sum;
        acc_t near_sum;
        logic any_out;
        logic any_part;
        any_out  = 1'b0;
        any_part = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            far_sum  = dw4_reg[p] + r4_reg[p];
            near_sum = dw4_reg[p] - r4_reg[p];
            any_out  = any_out  | far_sum[ACC_W-1];
            any_part = any_part | near_sum[ACC_W-1];
        end
        if (any_out) begin
            verdict5_next = VERDICT_OUTSIDE;
        end else if (any_part) begin
            verdict5_next = VERDICT_PARTIAL;
        end else begin
            verdict5_next = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && accept) begin
            ctr1_reg  <= ctr1_next;
            half1_reg <= half1_next;
        end
        if (rdy2 && v1_reg) begin
            rowprod2_reg <= rowprod2_next;
            rprod2_reg   <= rprod2_next;
        end
        if (rdy3 && v2_reg) begin
            rowsum3_reg <= rowsum3_next;
            rsum3_reg   <= rsum3_next;
        end
        if (rdy4 && v3_reg) begin
            dw4_reg <= dw4_next;
            r4_reg  <= rsum3_reg;
        end
        if (rdy5 && v4_reg) begin
            verdict5_reg <= verdict5_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = M_TDATA_W'(verdict5_reg);

    a_no_accept_on_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !s_tready)
        else $error("input beat taken during a configuration beat");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted beat missing from first stage");

    a_s2_to_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("product stage beat lost");

    a_s4_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && rdy5) |=> (m_tvalid && (m_tdata[VERDICT_W-1:0] != 2'd3)))
        else $error("verdict missing or malformed");

endmodule
